### rtl/core/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Used by every module under rtl/core; depends on nothing else.
package tcw_pkg;

    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;

    localparam int KIND_W = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int COL_W  = 7;
    localparam int LINE_W = 5;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [ATTR_W-1:0] GREY_ATTR    = 8'd7;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_column;
        logic [LINE_W-1:0] cursor_line;
        logic [CHAR_W-1:0] read_char;
        logic [ATTR_W-1:0] read_attr;
    } out_item_t;

    // Memory port requests from the sweep unit to the sequencer.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_zero;
        logic done;
    } sweep_ctl_t;

endpackage

### rtl/core/text_console_writer.sv
// Text console writer: for a beat that needs no sweep, ST_FINISH registers the
// result onto m_valid once the output is free; no new item is taken until then.
// A put that scrolls, and a clear, first run the sweep unit, which walks the
// cell store one cell per cycle over its single write port.
// After reset the same sweep zeroes the store while s_ready stays low.
// Depends on tcw_pkg, tcw_sweep, tcw_cell_ram.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEFAULT_COLUMNS,
    parameter int ROWS    = DEFAULT_ROWS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int AW        = $clog2(CELLS);
    localparam int CW        = $clog2(COLUMNS);
    localparam int RW        = $clog2(ROWS);
    localparam int LAST_BASE = (ROWS - 1) * COLUMNS;
    localparam int CMPW      = ((AW > IDX_W) ? AW : IDX_W) + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    state_t        state_reg, state_next;
    logic          pend_reg, pend_next;
    logic          rd_sel_reg, rd_sel_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] base_reg, base_next;
    logic          m_valid_reg, m_valid_next;
    out_item_t     m_data_reg, m_data_next;

    sweep_ctl_t        sw_ctl;
    logic [AW-1:0]     sw_rd_addr;
    logic [AW-1:0]     sw_wr_addr;
    logic              sw_start;
    logic              sw_clear;

    logic              put_wr;
    logic              put_rd;
    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [CELL_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [CELL_W-1:0] ram_rd_data;

    logic          accept;
    logic          col_last;
    logic          at_bottom;
    logic          idx_ok;
    logic [AW:0]   next_base;

    assign accept    = s_valid && s_ready;
    assign col_last  = (col_reg == CW'(COLUMNS - 1));
    assign at_bottom = (row_reg == RW'(ROWS - 1));
    assign idx_ok    = (CMPW'(s_data.cell_index) < CMPW'(CELLS));
    assign next_base = {1'b0, base_reg} + (AW+1)'(COLUMNS);

    always_comb begin
        state_next   = state_reg;
        pend_next    = pend_reg;
        rd_sel_next  = rd_sel_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        addr_next    = addr_reg;
        base_next    = base_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        sw_start     = 1'b0;
        sw_clear     = 1'b0;
        put_wr       = 1'b0;
        put_rd       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    rd_sel_next = 1'b0;
                    state_next  = ST_FINISH;
                    unique case (s_data.kind)
                        KIND_PUT: begin
                            put_wr = (s_data.char_code != NEWLINE_CODE);
                            if (s_data.char_code == NEWLINE_CODE || col_last) begin
                                col_next = '0;
                                if (at_bottom) begin
                                    // The cursor ran off the last row: scroll up.
                                    addr_next  = AW'(LAST_BASE);
                                    base_next  = AW'(LAST_BASE);
                                    sw_start   = 1'b1;
                                    pend_next  = 1'b1;
                                    state_next = ST_SWEEP;
                                end else begin
                                    row_next  = row_reg + RW'(1);
                                    addr_next = next_base[AW-1:0];
                                    base_next = next_base[AW-1:0];
                                end
                            end else begin
                                col_next  = col_reg + CW'(1);
                                addr_next = addr_reg + AW'(1);
                            end
                        end
                        KIND_CLEAR: begin
                            sw_start   = 1'b1;
                            sw_clear   = 1'b1;
                            pend_next  = 1'b1;
                            state_next = ST_SWEEP;
                        end
                        KIND_READ: begin
                            put_rd      = idx_ok;
                            rd_sel_next = idx_ok;
                        end
                        default: begin
                            rd_sel_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                if (sw_ctl.done) begin
                    pend_next  = 1'b0;
                    state_next = pend_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.cursor_column = COL_W'(col_reg);
                    m_data_next.cursor_line   = LINE_W'(row_reg);
                    m_data_next.read_char     = rd_sel_reg ? ram_rd_data[CHAR_W-1:0] : '0;
                    m_data_next.read_attr     = rd_sel_reg ? ram_rd_data[CELL_W-1:CHAR_W] : '0;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A put write or an accepted read takes the memory ports; otherwise the sweep unit drives them.
    always_comb begin
        if (put_wr) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_reg;
            ram_wr_data = {GREY_ATTR, s_data.char_code};
        end else begin
            ram_wr_en   = sw_ctl.wr_en;
            ram_wr_addr = sw_wr_addr;
            ram_wr_data = sw_ctl.wr_zero ? '0 : ram_rd_data;
        end
        if (put_rd) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(s_data.cell_index);
        end else begin
            ram_rd_en   = sw_ctl.rd_en;
            ram_rd_addr = sw_rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SWEEP;
            pend_reg    <= 1'b0;
            rd_sel_reg  <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            addr_reg    <= '0;
            base_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            rd_sel_reg  <= rd_sel_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            addr_reg    <= addr_next;
            base_reg    <= base_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    tcw_sweep #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_sweep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (sw_start),
        .clear_mode (sw_clear),
        .ctl        (sw_ctl),
        .rd_addr    (sw_rd_addr),
        .wr_addr    (sw_wr_addr)
    );

    tcw_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

### rtl/core/tcw_cell_ram.sv
// Screen cell store: one write port and one registered read port.
// Depends on tcw_pkg for the cell width.
module tcw_cell_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH = DEFAULT_COLUMNS * DEFAULT_ROWS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [CELL_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [CELL_W-1:0] rd_data
);

    logic [CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/tcw_sweep.sv
// Address sweep unit: walks every cell once, copying each cell from one row
// below (scroll, last row zeroed) or writing zero (clear). Depends on tcw_pkg.
module tcw_sweep
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEFAULT_COLUMNS,
    parameter int ROWS    = DEFAULT_ROWS,
    parameter int AW      = $clog2(COLUMNS * ROWS)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic          clear_mode,
    output sweep_ctl_t    ctl,
    output logic [AW-1:0] rd_addr,
    output logic [AW-1:0] wr_addr
);

    localparam int CELLS = COLUMNS * ROWS;

    logic          active_reg, active_next;
    logic          mode_reg, mode_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          wb_valid_reg, wb_valid_next;
    logic [AW-1:0] wb_addr_reg, wb_addr_next;
    logic          wb_zero_reg, wb_zero_next;
    logic          in_range;
    logic          has_source;
    logic [AW:0]   src_addr;

    assign in_range   = (cnt_reg < (AW+1)'(CELLS));
    assign has_source = (cnt_reg < (AW+1)'(CELLS - COLUMNS));
    assign src_addr   = cnt_reg + (AW+1)'(COLUMNS);

    always_comb begin
        active_next   = active_reg;
        mode_next     = mode_reg;
        cnt_next      = cnt_reg;
        wb_valid_next = 1'b0;
        wb_addr_next  = wb_addr_reg;
        wb_zero_next  = wb_zero_reg;
        ctl.rd_en     = 1'b0;
        ctl.wr_en     = wb_valid_reg;
        ctl.wr_zero   = wb_zero_reg;
        ctl.done      = active_reg && !in_range;
        rd_addr       = src_addr[AW-1:0];

        if (start) begin
            active_next = 1'b1;
            mode_next   = clear_mode;
            cnt_next    = '0;
        end else if (active_reg) begin
            if (in_range) begin
                // Read the cell one row below now; it is written back next cycle.
                ctl.rd_en     = !mode_reg && has_source;
                wb_valid_next = 1'b1;
                wb_addr_next  = cnt_reg[AW-1:0];
                wb_zero_next  = mode_reg || !has_source;
                cnt_next      = cnt_reg + (AW+1)'(1);
            end else begin
                active_next = 1'b0;
            end
        end
    end

    assign wr_addr = wb_addr_reg;

    // Reset starts a clearing pass over the whole store.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b1;
            mode_reg     <= 1'b1;
            cnt_reg      <= '0;
            wb_valid_reg <= 1'b0;
        end else begin
            active_reg   <= active_next;
            mode_reg     <= mode_next;
            cnt_reg      <= cnt_next;
            wb_valid_reg <= wb_valid_next;
        end
        wb_addr_reg <= wb_addr_next;
        wb_zero_reg <= wb_zero_next;
    end

endmodule

### rtl/core/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer.
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEFAULT_COLUMNS,
    parameter int ROWS    = DEFAULT_ROWS
) (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // Reset always starts the clearing pass, so no beat can be taken right after it.
    a_reset_busy: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input taken right after reset");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second beat accepted while an item is in work");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result beat changed");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((COLUMNS > 128 || m_data.cursor_column < COLUMNS) &&
                     (ROWS > 32 || m_data.cursor_line < ROWS)))
        else $error("cursor outside the screen");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
